// ===== hdl/etc_pkg.sv =====
// Shared types, codes and sizing constants for the edge-triggered capture unit.
package etc_pkg;

   localparam int BufferDepth  = 1024;
   localparam int AddrWidth    = $clog2(BufferDepth);
   localparam int CountWidth   = (AddrWidth + 1 > 11) ? AddrWidth + 1 : 11;
   localparam int SampleWidth  = 8;
   localparam int ChannelCount = 8;
   localparam int CsrDataWidth = 16;

   localparam logic [15:0] IntervalReset = 16'd10;
   localparam logic [10:0] CountReset    = 11'd0;
   localparam logic [3:0]  ChannelReset  = 4'd0;

   typedef enum logic [2:0] {
      OP_TICK        = 3'd0,
      OP_ARM         = 3'd1,
      OP_STOP        = 3'd2,
      OP_CLEAR_READY = 3'd3,
      OP_READ_ENTRY  = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_SAMPLE_INTERVAL = 2'd0,
      CSR_SAMPLE_COUNT    = 2'd1,
      CSR_TRIGGER_CHANNEL = 2'd2,
      CSR_TRIGGER_EDGE    = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      EDGE_RISING    = 2'd0,
      EDGE_FALLING   = 2'd1,
      EDGE_ANY       = 2'd2,
      EDGE_IMMEDIATE = 2'd3
   } edge_mode_type;

   typedef struct packed {
      logic [2:0]             opcode;
      logic [SampleWidth-1:0] port_value;
      logic [9:0]             read_index;
   } req_type;

   typedef struct packed {
      logic [SampleWidth-1:0] read_data;
      logic                   stored;
      logic                   buffer_ready;
      logic                   running;
      logic                   is_triggered;
   } rsp_type;

   typedef struct packed {
      logic stored;
      logic buffer_ready;
      logic running;
      logic is_triggered;
   } status_type;

   typedef struct packed {
      logic                   en;
      logic [AddrWidth-1:0]   addr;
      logic [SampleWidth-1:0] data;
   } mem_write_type;

endpackage

// ===== hdl/edge_triggered_capture_unit.sv =====
// Top level of the edge-triggered capture unit: engine, sample buffer and response stages.
//
// Each request transfer carries an opcode (tick, arm, stop, clear ready, read entry), the
// current 8-bit port value and a buffer index. Every request produces exactly one response
// transfer with the read data (zero unless the opcode reads an entry), the stored bit and
// the ready, running and triggered flags as they stand after that request.
// One request is taken per cycle while responses drain. A response passes through the
// registered read of the sample buffer and then the output register.
// Flags are updated in the cycle a request is taken, and a sample write lands in the buffer
// before any later read can issue, so back-to-back requests need no interlock.
// The csr port writes one register per write, selected by csr_index: interval, count,
// trigger channel or edge mode; write it only while no request is in flight.
// Reset clears the flags, counters and response stages and loads the register defaults
// (interval 10, count 0, channel 0, immediate trigger). The buffer is not cleared.
// When the receiver stalls, one response waits in the output register while a second one
// is taken into the buffer read stage; further requests are held off until space frees.
module edge_triggered_capture_unit import etc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  req_type                 req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rsp_type                 rsp_data,
   input  logic                    csr_we,
   input  logic [1:0]              csr_index,
   input  logic [CsrDataWidth-1:0] csr_wdata
);

   logic                   req_accept;
   logic                   s1_advance;
   logic                   rd_en;
   logic [SampleWidth-1:0] rd_data;
   mem_write_type          mem_wr;
   status_type             status;

   logic                   s1_valid_ff;
   status_type             s1_status_ff;
   logic                   s1_read_ff;
   logic                   out_valid_ff;
   rsp_type                out_data_ff;

   assign req_accept = req_valid && req_ready;
   assign s1_advance = !out_valid_ff || rsp_ready;
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign rd_en      = req_accept && (req_data.opcode == OP_READ_ENTRY);

   etc_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .req       (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .mem_wr    (mem_wr),
      .status    (status)
   );

   etc_ram #(
      .Width (SampleWidth),
      .Depth (BufferDepth)
   ) u_sample_ram (
      .clock   (clock),
      .wr_en   (mem_wr.en),
      .wr_addr (mem_wr.addr),
      .wr_data (mem_wr.data),
      .rd_en   (rd_en),
      .rd_addr (AddrWidth'(req_data.read_index)),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_status_ff <= status;
         s1_read_ff   <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_valid_ff) begin
         out_data_ff.read_data    <= s1_read_ff ? rd_data : '0;
         out_data_ff.stored       <= s1_status_ff.stored;
         out_data_ff.buffer_ready <= s1_status_ff.buffer_ready;
         out_data_ff.running      <= s1_status_ff.running;
         out_data_ff.is_triggered <= s1_status_ff.is_triggered;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   a_write_on_accept: assert property (@(posedge clock) disable iff (reset)
      mem_wr.en |-> req_accept)
      else $error("Sample buffer written without a request transfer.");

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_advance |=> s1_valid_ff && $stable(s1_status_ff)
                                      && $stable(s1_read_ff))
      else $error("Buffer read stage changed while stalled.");

   a_store_while_running: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.stored |-> rsp_data.running && rsp_data.read_data == '0)
      else $error("Stored sample reported outside a running tick.");

endmodule

// ===== hdl/etc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module etc_ram #(
   parameter int Width = 8,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/etc_engine.sv =====
// Capture control: configuration registers, interval counter, trigger and buffer position.
module etc_engine import etc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  req_type                 req,
   input  logic                    csr_we,
   input  logic [1:0]              csr_index,
   input  logic [CsrDataWidth-1:0] csr_wdata,
   output mem_write_type           mem_wr,
   output status_type              status
);

   logic [15:0]            sample_interval_ff;
   logic [10:0]            sample_count_ff;
   logic [3:0]             trigger_channel_ff;
   edge_mode_type          trigger_edge_ff;

   logic [AddrWidth-1:0]   write_index_ff, write_index_in;
   logic [SampleWidth-1:0] last_port_ff, last_port_in;
   logic [15:0]            elapsed_ff, elapsed_in;
   logic                   ready_ff, ready_in;
   logic                   run_ff, run_in;
   logic                   trig_ff, trig_in;

   logic [15:0]            interval_eff;
   logic [15:0]            elapsed_inc;
   logic [CountWidth-1:0]  count_ext;
   logic [CountWidth-1:0]  count_eff;
   logic [CountWidth-1:0]  index_plus;
   logic                   no_channel;
   logic                   preset;
   logic                   prev_bit;
   logic                   curr_bit;
   logic                   hit;
   logic                   stored;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_interval_ff <= IntervalReset;
         sample_count_ff    <= CountReset;
         trigger_channel_ff <= ChannelReset;
         trigger_edge_ff    <= EDGE_IMMEDIATE;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_SAMPLE_INTERVAL: sample_interval_ff <= csr_wdata[15:0];
            CSR_SAMPLE_COUNT:    sample_count_ff    <= csr_wdata[10:0];
            CSR_TRIGGER_CHANNEL: trigger_channel_ff <= csr_wdata[3:0];
            CSR_TRIGGER_EDGE:    trigger_edge_ff    <= edge_mode_type'(csr_wdata[1:0]);
            default: ;
         endcase
      end
   end

   assign interval_eff = (sample_interval_ff == '0) ? 16'd1 : sample_interval_ff;
   assign elapsed_inc  = (elapsed_ff == 16'hFFFF) ? elapsed_ff : elapsed_ff + 16'd1;
   assign count_ext    = CountWidth'(sample_count_ff);
   assign count_eff    = (count_ext == '0 || count_ext > CountWidth'(BufferDepth)) ?
                         CountWidth'(BufferDepth) : count_ext;
   assign index_plus   = CountWidth'(write_index_ff) + CountWidth'(1);
   assign no_channel   = trigger_channel_ff >= 4'(ChannelCount);
   assign preset       = (trigger_edge_ff == EDGE_IMMEDIATE) || no_channel;
   assign prev_bit     = no_channel ? 1'b0 : last_port_ff[trigger_channel_ff[2:0]];
   assign curr_bit     = no_channel ? 1'b0 : req.port_value[trigger_channel_ff[2:0]];

   always_comb begin
      write_index_in = write_index_ff;
      last_port_in   = last_port_ff;
      elapsed_in     = elapsed_ff;
      ready_in       = ready_ff;
      run_in         = run_ff;
      trig_in        = trig_ff;
      hit            = 1'b0;
      stored         = 1'b0;
      if (accept) begin
         case (opcode_type'(req.opcode))
            OP_TICK: begin
               if (run_ff && !ready_ff) begin
                  if (elapsed_inc < interval_eff) begin
                     elapsed_in = elapsed_inc;
                  end else begin
                     elapsed_in = '0;
                     if (!trig_ff) begin
                        case (trigger_edge_ff)
                           EDGE_RISING:  hit = !prev_bit && curr_bit;
                           EDGE_FALLING: hit = prev_bit && !curr_bit;
                           EDGE_ANY:     hit = prev_bit != curr_bit;
                           default:      hit = 1'b0;
                        endcase
                        last_port_in = req.port_value;
                     end
                     if (trig_ff || hit) begin
                        stored  = 1'b1;
                        trig_in = 1'b1;
                        if (index_plus >= count_eff) begin
                           ready_in       = 1'b1;
                           write_index_in = '0;
                           trig_in        = preset;
                        end else begin
                           write_index_in = index_plus[AddrWidth-1:0];
                        end
                     end
                  end
               end
            end
            OP_ARM: begin
               write_index_in = '0;
               ready_in       = 1'b0;
               last_port_in   = req.port_value;
               trig_in        = preset;
               elapsed_in     = '0;
               run_in         = 1'b1;
            end
            OP_STOP: begin
               write_index_in = '0;
               ready_in       = 1'b0;
               run_in         = 1'b0;
            end
            OP_CLEAR_READY: begin
               ready_in = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_index_ff <= '0;
         last_port_ff   <= '0;
         elapsed_ff     <= '0;
         ready_ff       <= 1'b0;
         run_ff         <= 1'b0;
         trig_ff        <= 1'b0;
      end else begin
         write_index_ff <= write_index_in;
         last_port_ff   <= last_port_in;
         elapsed_ff     <= elapsed_in;
         ready_ff       <= ready_in;
         run_ff         <= run_in;
         trig_ff        <= trig_in;
      end
   end

   assign mem_wr.en           = stored;
   assign mem_wr.addr         = write_index_ff;
   assign mem_wr.data         = req.port_value;
   assign status.stored       = stored;
   assign status.buffer_ready = ready_in;
   assign status.running      = run_in;
   assign status.is_triggered = trig_in;

endmodule
